FILE: rtl/core/tmae_pkg.sv
// Shared command and status codes and small index helpers for the mesh adjacency core.
package tmae_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR      = 3'd0,
        CMD_ADD        = 3'd1,
        CMD_QUERY      = 3'd2,
        CMD_RING_START = 3'd3,
        CMD_RING_STEP  = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_RING  = 2'd2
    } mode_t;

    // Next corner index, modulo three.
    function automatic logic [1:0] mod3_inc(input logic [1:0] x);
        mod3_inc = (x == 2'd2) ? 2'd0 : x + 2'd1;
    endfunction

    // Previous corner index, modulo three.
    function automatic logic [1:0] mod3_dec(input logic [1:0] x);
        mod3_dec = (x == 2'd0) ? 2'd2 : x - 2'd1;
    endfunction

endpackage

FILE: rtl/core/triangle_mesh_adjacency_engine_core.sv
// Errors and empty ring steps are answered straight from idle; clear writes every node
// memory entry; add, query and ring step walk the per-node edge chains (one edge entry
// a cycle). One command at a time: start is taken only while idle, and busy is high
// from accept and falls as done rises (commands answered straight from idle never raise busy).
// Reset runs a clearing pass over the node memory (busy high, no done beat).
// Results are shown for one cycle on done; the receiver cannot stall.
module triangle_mesh_adjacency_engine_core #(
    parameter int MAX_NODES     = 4096,
    parameter int MAX_TRIANGLES = 8192
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [tmae_pkg::CMD_W-1:0]             command,
    input  logic [$clog2(MAX_NODES+1)-1:0]         node_a,
    input  logic [$clog2(MAX_NODES+1)-1:0]         node_b,
    input  logic [$clog2(MAX_NODES+1)-1:0]         node_c,
    input  logic [$clog2(MAX_TRIANGLES+1)-1:0]     triangle,
    output logic                                   done,
    output logic [$clog2(MAX_TRIANGLES+1)-1:0]     result_triangle,
    output logic [$clog2(MAX_TRIANGLES+1)-1:0]     adj_first,
    output logic [$clog2(MAX_TRIANGLES+1)-1:0]     adj_second,
    output logic [$clog2(MAX_TRIANGLES+1)-1:0]     adj_third,
    output logic [$clog2(MAX_NODES+1)-1:0]         opp_first,
    output logic [$clog2(MAX_NODES+1)-1:0]         opp_second,
    output logic [$clog2(MAX_NODES+1)-1:0]         opp_third,
    output logic                                   more,
    output logic [tmae_pkg::STATUS_W-1:0]          status
);
    import tmae_pkg::*;

    localparam int EDGE_CAP = 3 * MAX_TRIANGLES;
    localparam int NW  = $clog2(MAX_NODES + 1);
    localparam int TW  = $clog2(MAX_TRIANGLES + 1);
    localparam int EW  = $clog2(EDGE_CAP + 1);
    localparam int CIW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int XW  = $clog2(EDGE_CAP);

    typedef logic [2:0][NW-1:0] corners_t;

    typedef struct packed {
        logic [TW-1:0] last;
        logic [EW-1:0] head;
    } node_t;

    typedef struct packed {
        logic [EW-1:0] next;
        logic [NW-1:0] nd;
        logic [TW-1:0] nt0;
        logic [TW-1:0] nt1;
        logic [NW-1:0] nn0;
        logic [NW-1:0] nn1;
    } edge_t;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_CLR    = 13'b0000000000010,
        S_FSTART = 13'b0000000000100,
        S_FNODE  = 13'b0000000001000,
        S_FEDGE  = 13'b0000000010000,
        S_LRD    = 13'b0000000100000,
        S_LWR    = 13'b0000001000000,
        S_NCORN  = 13'b0000010000000,
        S_RNEXT  = 13'b0000100000000,
        S_RCHK   = 13'b0001000000000,
        S_RBACK  = 13'b0010000000000,
        S_RSNODE = 13'b0100000000000,
        S_RSCORN = 13'b1000000000000
    } state_t;

    // Memories
    corners_t corner_mem [MAX_TRIANGLES];
    node_t    node_mem   [MAX_NODES+1];
    edge_t    edge_mem   [EDGE_CAP];

    logic           cm_we, cm_re;
    logic [CIW-1:0] cm_waddr;
    logic [TW-1:0]  cm_rtri, cm_ridx;
    corners_t       cm_wdata, cm_rdata;

    logic           nd_we, nd_re;
    logic [NW-1:0]  nd_waddr, nd_raddr;
    node_t          nd_wdata, nd_rdata;

    logic           ed_we, ed_re;
    logic [EW-1:0]  ed_wnum, ed_rnum, ed_widx, ed_ridx;
    edge_t          ed_wdata, ed_rdata;

    assign cm_ridx = cm_rtri - TW'(1);
    assign ed_widx = ed_wnum - EW'(1);
    assign ed_ridx = ed_rnum - EW'(1);

    always_ff @(posedge clk)
    begin
        if (cm_we)
        begin
            corner_mem[cm_waddr] <= cm_wdata;
        end
        if (cm_re)
        begin
            cm_rdata <= corner_mem[cm_ridx[CIW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nd_we)
        begin
            node_mem[nd_waddr] <= nd_wdata;
        end
        if (nd_re)
        begin
            nd_rdata <= node_mem[nd_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ed_we)
        begin
            edge_mem[ed_widx[XW-1:0]] <= ed_wdata;
        end
        if (ed_re)
        begin
            ed_rdata <= edge_mem[ed_ridx[XW-1:0]];
        end
    end

    // Control and working registers
    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic                clr_report_reg, clr_report_next;
    logic [NW-1:0]       clr_idx_reg, clr_idx_next;
    corners_t            cn_reg, cn_next;
    logic [1:0]          j_reg, j_next, i_reg, i_next;
    logic [TW-1:0]       cur_tri_reg, cur_tri_next;
    logic [EW-1:0]       idx_reg, idx_next;
    logic [EW-1:0]       head_reg, head_next;
    logic [TW-1:0]       last_reg, last_next;
    logic [2:0][TW-1:0]  adj_reg, adj_next;
    logic [2:0][NW-1:0]  opp_reg, opp_next;
    logic [TW-1:0]       tri_cnt_reg, tri_cnt_next;
    logic [EW-1:0]       edge_cnt_reg, edge_cnt_next;
    logic [NW-1:0]       ring_centre_reg, ring_centre_next;
    logic [TW-1:0]       ring_start_reg, ring_start_next;
    logic [TW-1:0]       ring_current_reg, ring_current_next;
    logic [NW-1:0]       ring_other_reg, ring_other_next;
    logic                ring_forward_reg, ring_forward_next;
    logic                ring_more_reg, ring_more_next;

    // Result registers
    logic                done_reg, done_next;
    logic [TW-1:0]       o_tri_reg, o_tri_next;
    logic [2:0][TW-1:0]  o_adj_reg, o_adj_next;
    logic [2:0][NW-1:0]  o_opp_reg, o_opp_next;
    logic                o_more_reg, o_more_next;
    status_t             o_status_reg, o_status_next;

    // Edge endpoints of the current corner pair
    logic [1:0]    j1, j2;
    logic [NW-1:0] ea, eb, lo, hi, eopp;

    assign j1   = mod3_inc(j_reg);
    assign j2   = mod3_dec(j_reg);
    assign ea   = cn_reg[j_reg];
    assign eb   = cn_reg[j1];
    assign lo   = (ea <= eb) ? ea : eb;
    assign hi   = (ea <= eb) ? eb : ea;
    assign eopp = cn_reg[j2];

    // Corner matching on the triangle just read
    logic       fwd_hit, bwd_hit, cp_none;
    logic [1:0] fwd_j, bwd_j, cp;

    always_comb
    begin
        fwd_hit = 1'b0;
        bwd_hit = 1'b0;
        cp_none = 1'b1;
        fwd_j   = 2'd0;
        bwd_j   = 2'd0;
        cp      = 2'd0;
        for (int k = 2; k >= 0; k--)
        begin
            if (cm_rdata[k] == ring_centre_reg &&
                cm_rdata[mod3_inc(2'(k))] == ring_other_reg)
            begin
                fwd_hit = 1'b1;
                fwd_j   = 2'(k);
            end
            if (cm_rdata[k] == ring_centre_reg &&
                cm_rdata[mod3_dec(2'(k))] == ring_other_reg)
            begin
                bwd_hit = 1'b1;
                bwd_j   = 2'(k);
            end
            if (cm_rdata[k] == ring_centre_reg)
            begin
                cp_none = 1'b0;
                cp      = 2'(k);
            end
        end
    end

    logic          res_go, res_found, nb_side;
    logic [EW-1:0] r_head, new_edge;
    logic [TW-1:0] r_last, new_tri;

    assign new_edge = edge_cnt_reg + EW'(1);
    assign new_tri  = tri_cnt_reg + TW'(1);
    assign nb_side  = (ed_rdata.nt0 == cur_tri_reg);

    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        clr_report_next   = clr_report_reg;
        clr_idx_next      = clr_idx_reg;
        cn_next           = cn_reg;
        j_next            = j_reg;
        i_next            = i_reg;
        cur_tri_next      = cur_tri_reg;
        idx_next          = idx_reg;
        head_next         = head_reg;
        last_next         = last_reg;
        adj_next          = adj_reg;
        opp_next          = opp_reg;
        tri_cnt_next      = tri_cnt_reg;
        edge_cnt_next     = edge_cnt_reg;
        ring_centre_next  = ring_centre_reg;
        ring_start_next   = ring_start_reg;
        ring_current_next = ring_current_reg;
        ring_other_next   = ring_other_reg;
        ring_forward_next = ring_forward_reg;
        ring_more_next    = ring_more_reg;

        done_next     = 1'b0;
        o_tri_next    = '0;
        o_adj_next    = '0;
        o_opp_next    = '0;
        o_more_next   = 1'b0;
        o_status_next = ST_OK;

        cm_we = 1'b0; cm_waddr = '0; cm_wdata = cn_reg; cm_re = 1'b0; cm_rtri = '0;
        nd_we = 1'b0; nd_waddr = '0; nd_wdata = '0; nd_re = 1'b0; nd_raddr = '0;
        ed_we = 1'b0; ed_wnum = '0; ed_wdata = ed_rdata; ed_re = 1'b0; ed_rnum = '0;

        res_go    = 1'b0;
        res_found = 1'b0;
        r_head    = head_reg;
        r_last    = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd_t'(command))
                        CMD_CLEAR:
                        begin
                            tri_cnt_next      = '0;
                            edge_cnt_next     = '0;
                            ring_centre_next  = '0;
                            ring_start_next   = '0;
                            ring_current_next = '0;
                            ring_other_next   = '0;
                            ring_forward_next = 1'b0;
                            ring_more_next    = 1'b0;
                            clr_idx_next      = '0;
                            clr_report_next   = 1'b1;
                            state_next        = S_CLR;
                        end
                        CMD_ADD:
                        begin
                            if (node_a == '0 || node_b == '0 || node_c == '0 ||
                                node_a > NW'(MAX_NODES) || node_b > NW'(MAX_NODES) ||
                                node_c > NW'(MAX_NODES))
                            begin
                                done_next     = 1'b1;
                                o_status_next = ST_RANGE;
                            end
                            else if (tri_cnt_reg >= TW'(MAX_TRIANGLES) ||
                                     {1'b0, edge_cnt_reg} + (EW+1)'(3) >
                                     (EW+1)'(EDGE_CAP))
                            begin
                                done_next     = 1'b1;
                                o_status_next = ST_FULL;
                            end
                            else
                            begin
                                tri_cnt_next = new_tri;
                                cur_tri_next = new_tri;
                                cn_next      = {node_c, node_b, node_a};
                                cm_we        = 1'b1;
                                cm_waddr     = tri_cnt_reg[CIW-1:0];
                                cm_wdata     = {node_c, node_b, node_a};
                                mode_next    = MODE_ADD;
                                j_next       = 2'd0;
                                state_next   = S_FSTART;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (triangle == '0 || triangle > tri_cnt_reg)
                            begin
                                done_next     = 1'b1;
                                o_status_next = ST_RANGE;
                            end
                            else
                            begin
                                cm_re        = 1'b1;
                                cm_rtri      = triangle;
                                cur_tri_next = triangle;
                                mode_next    = MODE_QUERY;
                                state_next   = S_NCORN;
                            end
                        end
                        CMD_RING_START:
                        begin
                            if (node_a == '0 || node_a > NW'(MAX_NODES))
                            begin
                                ring_current_next = '0;
                                ring_more_next    = 1'b0;
                                done_next         = 1'b1;
                                o_status_next     = ST_RANGE;
                            end
                            else
                            begin
                                ring_centre_next = node_a;
                                nd_re            = 1'b1;
                                nd_raddr         = node_a;
                                state_next       = S_RSNODE;
                            end
                        end
                        CMD_RING_STEP:
                        begin
                            if (ring_current_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                cm_re        = 1'b1;
                                cm_rtri      = ring_current_reg;
                                cur_tri_next = ring_current_reg;
                                mode_next    = MODE_RING;
                                state_next   = S_NCORN;
                            end
                        end
                        default:
                        begin
                            done_next     = 1'b1;
                            o_status_next = ST_RANGE;
                        end
                    endcase
                end
            end

            S_CLR:
            begin
                nd_we    = 1'b1;
                nd_waddr = clr_idx_reg;
                nd_wdata = '0;
                if (clr_idx_reg == NW'(MAX_NODES))
                begin
                    done_next  = clr_report_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + NW'(1);
                end
            end

            S_NCORN:
            begin
                cn_next    = cm_rdata;
                j_next     = 2'd0;
                state_next = S_FSTART;
            end

            S_FSTART:
            begin
                nd_re      = 1'b1;
                nd_raddr   = lo;
                state_next = S_FNODE;
            end

            S_FNODE:
            begin
                head_next = nd_rdata.head;
                last_next = nd_rdata.last;
                r_head    = nd_rdata.head;
                r_last    = nd_rdata.last;
                if (nd_rdata.head == '0)
                begin
                    res_go = 1'b1;
                end
                else
                begin
                    ed_re      = 1'b1;
                    ed_rnum    = nd_rdata.head;
                    idx_next   = nd_rdata.head;
                    state_next = S_FEDGE;
                end
            end

            S_FEDGE:
            begin
                if (ed_rdata.nd == hi)
                begin
                    res_go    = 1'b1;
                    res_found = 1'b1;
                end
                else if (ed_rdata.next == '0)
                begin
                    res_go = 1'b1;
                end
                else
                begin
                    ed_re    = 1'b1;
                    ed_rnum  = ed_rdata.next;
                    idx_next = ed_rdata.next;
                end
            end

            S_LRD:
            begin
                nd_re      = 1'b1;
                nd_raddr   = cn_reg[j_reg];
                state_next = S_LWR;
            end

            S_LWR:
            begin
                nd_we    = 1'b1;
                nd_waddr = cn_reg[j_reg];
                nd_wdata = '{last: cur_tri_reg, head: nd_rdata.head};
                if (j_reg == 2'd2)
                begin
                    done_next  = 1'b1;
                    o_tri_next = cur_tri_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    j_next     = j1;
                    state_next = S_LRD;
                end
            end

            S_RNEXT:
            begin
                if (i_reg == 2'd3)
                begin
                    if (ring_forward_reg)
                    begin
                        cm_re      = 1'b1;
                        cm_rtri    = ring_start_reg;
                        state_next = S_RBACK;
                    end
                    else
                    begin
                        ring_more_next = 1'b0;
                        done_next      = 1'b1;
                        o_tri_next     = ring_current_reg;
                        state_next     = S_IDLE;
                    end
                end
                else if (adj_reg[i_reg] == '0)
                begin
                    i_next = i_reg + 2'd1;
                end
                else
                begin
                    cm_re      = 1'b1;
                    cm_rtri    = adj_reg[i_reg];
                    state_next = S_RCHK;
                end
            end

            S_RCHK:
            begin
                if (ring_forward_reg && fwd_hit)
                begin
                    ring_current_next = adj_reg[i_reg];
                    ring_other_next   = cm_rdata[mod3_dec(fwd_j)];
                    ring_more_next    = (adj_reg[i_reg] != ring_start_reg);
                    done_next         = 1'b1;
                    o_tri_next        = adj_reg[i_reg];
                    o_more_next       = (adj_reg[i_reg] != ring_start_reg);
                    state_next        = S_IDLE;
                end
                else if (!ring_forward_reg && bwd_hit)
                begin
                    ring_current_next = adj_reg[i_reg];
                    ring_other_next   = cm_rdata[mod3_inc(bwd_j)];
                    ring_more_next    = 1'b1;
                    done_next         = 1'b1;
                    o_tri_next        = adj_reg[i_reg];
                    o_more_next       = 1'b1;
                    state_next        = S_IDLE;
                end
                else
                begin
                    i_next     = i_reg + 2'd1;
                    state_next = S_RNEXT;
                end
            end

            S_RBACK:
            begin
                // Forward search ran out: restart backward from the first triangle.
                ring_other_next   = cm_rdata[cp_none ? 2'd1 : mod3_inc(cp)];
                ring_forward_next = 1'b0;
                ring_current_next = ring_start_reg;
                cur_tri_next      = ring_start_reg;
                cn_next           = cm_rdata;
                j_next            = 2'd0;
                state_next        = S_FSTART;
            end

            S_RSNODE:
            begin
                ring_start_next   = nd_rdata.last;
                ring_current_next = nd_rdata.last;
                ring_forward_next = 1'b1;
                ring_more_next    = (nd_rdata.last != '0);
                if (nd_rdata.last != '0)
                begin
                    cm_re      = 1'b1;
                    cm_rtri    = nd_rdata.last;
                    state_next = S_RSCORN;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_RSCORN:
            begin
                ring_other_next = cm_rdata[cp_none ? 2'd2 : mod3_dec(cp)];
                done_next       = 1'b1;
                o_tri_next      = ring_start_reg;
                o_more_next     = 1'b1;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Edge lookup finished for corner pair j.
        if (res_go)
        begin
            if (mode_reg == MODE_ADD)
            begin
                ed_we = 1'b1;
                if (res_found)
                begin
                    ed_wnum      = idx_reg;
                    ed_wdata     = ed_rdata;
                    ed_wdata.nt1 = cur_tri_reg;
                    ed_wdata.nn1 = eopp;
                end
                else
                begin
                    ed_wnum       = new_edge;
                    ed_wdata      = '{next: r_head, nd: hi, nt0: cur_tri_reg, nt1: '0,
                                      nn0: eopp, nn1: '0};
                    nd_we         = 1'b1;
                    nd_waddr      = lo;
                    nd_wdata      = '{last: r_last, head: new_edge};
                    edge_cnt_next = new_edge;
                end
                if (j_reg == 2'd2)
                begin
                    j_next     = 2'd0;
                    state_next = S_LRD;
                end
                else
                begin
                    j_next     = j1;
                    state_next = S_FSTART;
                end
            end
            else
            begin
                if (res_found)
                begin
                    adj_next[j_reg] = nb_side ? ed_rdata.nt1 : ed_rdata.nt0;
                    opp_next[j_reg] = nb_side ? ed_rdata.nn1 : ed_rdata.nn0;
                end
                else
                begin
                    adj_next[j_reg] = '0;
                    opp_next[j_reg] = '0;
                end
                if (j_reg != 2'd2)
                begin
                    j_next     = j1;
                    state_next = S_FSTART;
                end
                else if (mode_reg == MODE_QUERY)
                begin
                    done_next  = 1'b1;
                    o_adj_next = adj_next;
                    o_opp_next = opp_next;
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next     = 2'd0;
                    state_next = S_RNEXT;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLR;
            mode_reg         <= MODE_ADD;
            clr_report_reg   <= 1'b0;
            clr_idx_reg      <= '0;
            tri_cnt_reg      <= '0;
            edge_cnt_reg     <= '0;
            ring_centre_reg  <= '0;
            ring_start_reg   <= '0;
            ring_current_reg <= '0;
            ring_other_reg   <= '0;
            ring_forward_reg <= 1'b0;
            ring_more_reg    <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            mode_reg         <= mode_next;
            clr_report_reg   <= clr_report_next;
            clr_idx_reg      <= clr_idx_next;
            tri_cnt_reg      <= tri_cnt_next;
            edge_cnt_reg     <= edge_cnt_next;
            ring_centre_reg  <= ring_centre_next;
            ring_start_reg   <= ring_start_next;
            ring_current_reg <= ring_current_next;
            ring_other_reg   <= ring_other_next;
            ring_forward_reg <= ring_forward_next;
            ring_more_reg    <= ring_more_next;
            done_reg         <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cn_reg       <= cn_next;
        j_reg        <= j_next;
        i_reg        <= i_next;
        cur_tri_reg  <= cur_tri_next;
        idx_reg      <= idx_next;
        head_reg     <= head_next;
        last_reg     <= last_next;
        adj_reg      <= adj_next;
        opp_reg      <= opp_next;
        o_tri_reg    <= o_tri_next;
        o_adj_reg    <= o_adj_next;
        o_opp_reg    <= o_opp_next;
        o_more_reg   <= o_more_next;
        o_status_reg <= o_status_next;
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign result_triangle = o_tri_reg;
    assign adj_first       = o_adj_reg[0];
    assign adj_second      = o_adj_reg[1];
    assign adj_third       = o_adj_reg[2];
    assign opp_first       = o_opp_reg[0];
    assign opp_second      = o_opp_reg[1];
    assign opp_third       = o_opp_reg[2];
    assign more            = o_more_reg;
    assign status          = o_status_reg;

    // A result beat only follows an accepted command or work in progress.
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start || busy))
        else $error("result beat without a command");

    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        tri_cnt_reg <= TW'(MAX_TRIANGLES) && edge_cnt_reg <= EW'(EDGE_CAP))
        else $error("triangle or edge count beyond capacity");

    a_more_needs_current: assert property (@(posedge clk) disable iff (!rst_n)
        ring_more_reg |-> ring_current_reg != '0)
        else $error("ring walk pending with no current triangle");

endmodule
